// ===== rtl/core/urs_pkg.sv =====
// Shared types and constants for the unbiased range sampler.
// No dependencies.
package urs_pkg;

  localparam int WORD_W = 64;
  localparam int IDX_W  = 8;
  localparam int QDEPTH = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_LOW  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_HIGH = IDX_W'(1);

  // Status codes
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_INV = 1'b1;

  // Interval info from the threshold unit to the front end
  typedef struct packed {
    logic              ready;
    logic              err;
    logic              single;
    logic              full;
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] thr;
  } cfg_info_t;

  // One queued word
  typedef struct packed {
    logic              need_mod;
    logic              status;
    logic [WORD_W-1:0] val;
  } q_entry_t;

  // One remainder pipeline stage
  typedef struct packed {
    logic              need_mod;
    logic              status;
    logic [WORD_W-1:0] val;
    logic [WORD_W-1:0] rem;
  } pipe_t;

endpackage

// ===== rtl/core/urs_thresh.sv =====
// Configuration registers, span and rejection threshold unit.
// Depends on urs_pkg. Bit-serial restoring remainder, one bit per cycle.
module urs_thresh
  import urs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  output cfg_info_t         info
);

  typedef enum logic [2:0] {
    S_SPAN = 3'b001,
    S_DIV  = 3'b010,
    S_RDY  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [WORD_W-1:0] low_r, high_r, span_r, dvd_r, rem_r;
  logic              err_r, single_r, full_r;
  logic [5:0]        cnt_r;
  logic [WORD_W:0]   trial;
  logic              cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == REG_LOW || cfg_index == REG_HIGH);
  assign trial   = {rem_r, dvd_r[WORD_W-1]};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SPAN: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 6'd63) state_nxt = S_RDY;
      S_RDY:  state_nxt = S_RDY;
      default: state_nxt = S_SPAN;
    endcase
    if (cfg_hit) state_nxt = S_SPAN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SPAN;
      low_r   <= '0;
      high_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == REG_LOW)  low_r  <= cfg_data;
      if (cfg_we && cfg_index == REG_HIGH) high_r <= cfg_data;
    end
  end

  // Datapath: span, flags, then 64 restoring steps on (0 - span)
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_SPAN: begin
        span_r   <= high_r - low_r + WORD_W'(1);
        dvd_r    <= WORD_W'(0) - (high_r - low_r + WORD_W'(1));
        err_r    <= low_r > high_r;
        single_r <= low_r == high_r;
        full_r   <= (high_r - low_r + WORD_W'(1)) == '0;
        rem_r    <= '0;
        cnt_r    <= '0;
      end
      S_DIV: begin
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + 6'd1;
        if (trial >= {1'b0, span_r}) rem_r <= WORD_W'(trial - {1'b0, span_r});
        else rem_r <= trial[WORD_W-1:0];
      end
      S_RDY: ;
      default: ;
    endcase
  end

  assign info.ready  = (state_r == S_RDY);
  assign info.err    = err_r;
  assign info.single = single_r;
  assign info.full   = full_r;
  assign info.low    = low_r;
  assign info.span   = span_r;
  assign info.thr    = full_r ? '0 : rem_r;

endmodule

// ===== rtl/core/urs_front.sv =====
// Front end: accepts words, classifies them, drops rejects, fills a short queue.
// Depends on urs_pkg.
module urs_front
  import urs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_info_t         info,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] in_random_word,
  output logic              q_valid,
  output q_entry_t          q_data,
  input  logic              q_pop
);

  q_entry_t   mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       acc, push;
  q_entry_t   ent;

  assign in_ready = info.ready && (cnt_r != 2'(QDEPTH));
  assign acc      = in_valid && in_ready;

  // Classify the word
  always_comb begin
    ent      = '{need_mod: 1'b0, status: ST_OK, val: in_random_word};
    push     = acc;
    priority if (info.err) begin
      ent.status = ST_INV;
      ent.val    = '0;
    end else if (info.single) begin
      ent.val = info.low;
    end else if (info.full) begin
      ent.val = in_random_word;
    end else begin
      ent.need_mod = 1'b1;
      push         = acc && (in_random_word >= info.thr);
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push)  wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/core/urs_back.sv =====
// Back end: pipelined remainder by span, one bit per stage, and output register.
// Depends on urs_pkg.
module urs_back
  import urs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_info_t         info,
  input  logic              q_valid,
  input  q_entry_t          q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_sample_value,
  output logic              out_status
);

  pipe_t             p_r [WORD_W+1];
  logic              v_r [WORD_W+1];
  logic              out_valid_r, out_status_r;
  logic [WORD_W-1:0] out_value_r;
  logic              en;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && q_valid;

  // Stage 0 loads from the queue
  always_ff @(posedge clk) begin
    if (en) p_r[0] <= '{need_mod: q_data.need_mod, status: q_data.status,
                        val: q_data.val, rem: '0};
  end

  // Remainder stages, word bit taken MSB first
  for (genvar k = 0; k < WORD_W; k++) begin : g_stage
    logic [WORD_W:0] trial;
    pipe_t           stg_nxt;
    assign trial = {p_r[k].rem, p_r[k].val[WORD_W-1-k]};
    always_comb begin
      stg_nxt = p_r[k];
      if (trial >= {1'b0, info.span}) stg_nxt.rem = WORD_W'(trial - {1'b0, info.span});
      else stg_nxt.rem = trial[WORD_W-1:0];
    end
    always_ff @(posedge clk) begin
      if (en) p_r[k+1] <= stg_nxt;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k+1] <= 1'b0;
      else if (en) v_r[k+1] <= v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= q_valid;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v_r[WORD_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status_r <= p_r[WORD_W].status;
      out_value_r  <= p_r[WORD_W].need_mod ? info.low + p_r[WORD_W].rem : p_r[WORD_W].val;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_status       = out_status_r;

endmodule

// ===== rtl/core/unbiased_range_sampler.sv =====
// Top level of the unbiased range sampler.
// Depends on urs_pkg, urs_thresh, urs_front, urs_back.
//
//  channel | ports                              | direction
//  in      | in_valid/in_ready, in_random_word  | word in
//  out     | out_valid/out_ready, out_sample_value, out_status | result out
//  cfg     | cfg_we, cfg_index, cfg_data        | register write
//
// One word per cycle unless the output stalls or the threshold is busy;
// 64 remainder stages. After reset or a write to range_low/range_high
// the threshold unit runs (one remainder bit per cycle) with in_ready low.
// Rejected words leave no result. Output stall freezes the remainder pipe;
// the 2-entry queue then fills and drops in_ready.
module unbiased_range_sampler
  import urs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] in_random_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_sample_value,
  output logic              out_status
);

  cfg_info_t info;
  q_entry_t  q_data;
  logic      q_valid, q_pop;

  urs_thresh u_thresh (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .info
  );

  urs_front u_front (
    .clk, .rst_n, .info, .in_valid, .in_ready, .in_random_word,
    .q_valid, .q_data, .q_pop
  );

  urs_back u_back (
    .clk, .rst_n, .info, .q_valid, .q_data, .q_pop,
    .out_valid, .out_ready, .out_sample_value, .out_status
  );

endmodule

// ===== rtl/core/urs_checker.sv =====
// Port-level checks for the unbiased range sampler, bound to the top level.
// Depends on urs_pkg.
module urs_checker
  import urs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_we,
  input logic [IDX_W-1:0]  cfg_index,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_sample_value,
  input logic              out_status
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_value) && $stable(out_status))
    else $error("result changed under stall");

  // Error result carries zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_INV |-> out_sample_value == '0)
    else $error("error result with nonzero value");

  // A bound write forces a threshold recompute
  a_recompute: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == REG_LOW || cfg_index == REG_HIGH) |=> !in_ready)
    else $error("in_ready high during threshold recompute");

  // Nothing valid right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind unbiased_range_sampler urs_checker u_urs_checker (
  .clk, .rst_n, .cfg_we, .cfg_index, .in_ready, .out_valid, .out_ready,
  .out_sample_value, .out_status
);
